[rtl/dhcpop_pkg.sv]
package dhcpop_pkg;

  localparam logic [7:0] OPT_PAD     = 8'd0;
  localparam logic [7:0] OPT_MASK    = 8'd1;
  localparam logic [7:0] OPT_ROUTER  = 8'd3;
  localparam logic [7:0] OPT_MSGTYPE = 8'd53;
  localparam logic [7:0] OPT_END     = 8'd255;

  // Address options carry four value bytes; value_index saturates here.
  localparam logic [2:0] ADDR_LEN = 3'd4;

  localparam logic [7:0] EXPECTED_TYPE_RST = 8'd5;

  // Bit positions in the seen flags.
  localparam int SEEN_TYPE   = 0;
  localparam int SEEN_MASK   = 1;
  localparam int SEEN_ROUTER = 2;

  typedef enum logic [1:0] {
    PH_TYPE,
    PH_LEN,
    PH_VALUE,
    PH_DONE
  } phase_t;

  typedef struct packed {
    logic [7:0]  msg_type;
    logic        type_matches;
    logic [31:0] subnet_mask;
    logic        has_mask;
    logic [31:0] router_addr;
    logic        has_router;
    logic        truncated;
  } result_t;

endpackage

[rtl/dhcpop_parse.sv]
module dhcpop_parse
  import dhcpop_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       take,
  input  logic [7:0] opt_byte,
  input  logic       last_byte,
  input  logic [7:0] expected_type,
  output result_t    result
);

  phase_t      phase_r,  phase_nxt;
  logic [7:0]  cur_r,    cur_nxt;
  logic [7:0]  left_r,   left_nxt;
  logic [2:0]  vidx_r,   vidx_nxt;
  logic [2:0]  seen_r,   seen_nxt;
  logic [7:0]  type_r,   type_nxt;
  logic [31:0] mask_r,   mask_nxt;
  logic [31:0] router_r, router_nxt;

  logic short_addr;

  assign short_addr = ((cur_r == OPT_MASK) || (cur_r == OPT_ROUTER)) &&
                      (opt_byte < {5'd0, ADDR_LEN});

  // Next phase.
  always_comb begin
    phase_nxt = phase_r;
    case (phase_r)
      PH_TYPE: begin
        if (opt_byte == OPT_END) begin
          phase_nxt = PH_DONE;
        end else if (opt_byte != OPT_PAD) begin
          phase_nxt = PH_LEN;
        end
      end
      PH_LEN: begin
        phase_nxt = (opt_byte == 8'd0) ? PH_TYPE : PH_VALUE;
      end
      PH_VALUE: begin
        if (left_r == 8'd1) begin
          phase_nxt = PH_TYPE;
        end
      end
      PH_DONE: begin
        phase_nxt = PH_DONE;
      end
      default: begin
        phase_nxt = PH_TYPE;
      end
    endcase
  end

  // Option bookkeeping and value capture.
  always_comb begin
    cur_nxt    = cur_r;
    left_nxt   = left_r;
    vidx_nxt   = vidx_r;
    seen_nxt   = seen_r;
    type_nxt   = type_r;
    mask_nxt   = mask_r;
    router_nxt = router_r;
    case (phase_r)
      PH_TYPE: begin
        if ((opt_byte != OPT_END) && (opt_byte != OPT_PAD)) begin
          cur_nxt = opt_byte;
        end
      end
      PH_LEN: begin
        left_nxt = opt_byte;
        vidx_nxt = 3'd0;
        if (short_addr) begin
          cur_nxt = OPT_PAD;
        end
      end
      PH_VALUE: begin
        if (cur_r == OPT_MSGTYPE) begin
          if ((vidx_r == 3'd0) && !seen_r[SEEN_TYPE]) begin
            type_nxt           = opt_byte;
            seen_nxt[SEEN_TYPE] = 1'b1;
          end
        end else if ((cur_r == OPT_MASK) && (vidx_r < ADDR_LEN)) begin
          // A new mask option invalidates the earlier one until it completes.
          if (vidx_r == 3'd0) begin
            seen_nxt[SEEN_MASK] = 1'b0;
          end
          mask_nxt = {mask_r[23:0], opt_byte};
          if (vidx_r == ADDR_LEN - 3'd1) begin
            seen_nxt[SEEN_MASK] = 1'b1;
          end
        end else if ((cur_r == OPT_ROUTER) && (vidx_r < ADDR_LEN)) begin
          if (vidx_r == 3'd0) begin
            seen_nxt[SEEN_ROUTER] = 1'b0;
          end
          router_nxt = {router_r[23:0], opt_byte};
          if (vidx_r == ADDR_LEN - 3'd1) begin
            seen_nxt[SEEN_ROUTER] = 1'b1;
          end
        end
        if (vidx_r < ADDR_LEN) begin
          vidx_nxt = vidx_r + 3'd1;
        end
        left_nxt = left_r - 8'd1;
      end
      default: begin
        cur_nxt = cur_r;
      end
    endcase
  end

  // The result reflects the state after the current byte.
  always_comb begin
    result.msg_type     = seen_nxt[SEEN_TYPE] ? type_nxt : 8'd0;
    result.type_matches = seen_nxt[SEEN_TYPE] && (type_nxt == expected_type);
    result.subnet_mask  = seen_nxt[SEEN_MASK] ? mask_nxt : 32'd0;
    result.has_mask     = seen_nxt[SEEN_MASK];
    result.router_addr  = seen_nxt[SEEN_ROUTER] ? router_nxt : 32'd0;
    result.has_router   = seen_nxt[SEEN_ROUTER];
    result.truncated    = (phase_nxt == PH_LEN) || (phase_nxt == PH_VALUE);
  end

  // Control state returns to its start on the last beat of a packet.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_TYPE;
      cur_r   <= 8'd0;
      left_r  <= 8'd0;
      vidx_r  <= 3'd0;
      seen_r  <= 3'd0;
    end else if (take) begin
      if (last_byte) begin
        phase_r <= PH_TYPE;
        cur_r   <= 8'd0;
        left_r  <= 8'd0;
        vidx_r  <= 3'd0;
        seen_r  <= 3'd0;
      end else begin
        phase_r <= phase_nxt;
        cur_r   <= cur_nxt;
        left_r  <= left_nxt;
        vidx_r  <= vidx_nxt;
        seen_r  <= seen_nxt;
      end
    end
  end

  // Captured values are only read behind their seen flags.
  always_ff @(posedge clk) begin
    if (take) begin
      type_r   <= type_nxt;
      mask_r   <= mask_nxt;
      router_r <= router_nxt;
    end
  end

endmodule

[rtl/dhcpop_out.sv]
module dhcpop_out
  import dhcpop_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    load,
  input  result_t res_in,
  input  logic    out_stall,
  output logic    out_valid,
  output result_t res_out
);

  logic    valid_r, valid_nxt;
  result_t res_r;

  always_comb begin
    valid_nxt = valid_r;
    if (load) begin
      valid_nxt = 1'b1;
    end else if (!out_stall) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res_r <= res_in;
    end
  end

  assign out_valid = valid_r;
  assign res_out   = res_r;

endmodule

[rtl/dhcpop_option_parser_core.sv]
// DHCP options parser. Bytes of a packet's options area enter on the in_ channel,
// one per beat, with in_last_byte marking the final byte. Each beat updates the
// type-length-value parse state in the same cycle it is accepted; no beat other
// than the last produces a result.
// On the last beat, one result (message type, subnet mask, router address,
// their presence flags, the type match and the truncation flag) is loaded into
// the output register and shown on the out_ channel in the next cycle, and the
// parse state is cleared for the next packet.
// Throughput is one byte per cycle while in_stall is low: the parse update is a single stage between
// the state registers and the output register.
// The cfg_ channel writes the expected message type; it is always ready and
// should be used only while no packet is in progress. Reset sets it to 5.
// Reset (rst_n low, synchronous) clears the parse state and drops out_valid.
// When out_stall holds a result, non-final bytes of the next packet are still
// accepted; only a final byte is stalled until the pending result leaves.
module dhcp_option_parser_core
  import dhcpop_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_opt_byte,
  input  logic        in_last_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  out_msg_type,
  output logic        out_type_matches,
  output logic [31:0] out_subnet_mask,
  output logic        out_has_mask,
  output logic [31:0] out_router_addr,
  output logic        out_has_router,
  output logic        out_truncated,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [7:0]  cfg_expected_type
);

  logic [7:0] exp_type_r;
  logic       take;
  logic       load;
  result_t    parse_res;
  result_t    out_res;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      exp_type_r <= EXPECTED_TYPE_RST;
    end else if (cfg_valid && cfg_ready) begin
      exp_type_r <= cfg_expected_type;
    end
  end

  assign in_stall = out_valid && out_stall && in_last_byte;
  assign take     = in_valid && !in_stall;
  assign load     = take && in_last_byte;

  dhcpop_parse u_parse (
    .clk           (clk),
    .rst_n         (rst_n),
    .take          (take),
    .opt_byte      (in_opt_byte),
    .last_byte     (in_last_byte),
    .expected_type (exp_type_r),
    .result        (parse_res)
  );

  dhcpop_out u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (load),
    .res_in    (parse_res),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .res_out   (out_res)
  );

  assign out_msg_type     = out_res.msg_type;
  assign out_type_matches = out_res.type_matches;
  assign out_subnet_mask  = out_res.subnet_mask;
  assign out_has_mask     = out_res.has_mask;
  assign out_router_addr  = out_res.router_addr;
  assign out_has_router   = out_res.has_router;
  assign out_truncated    = out_res.truncated;

`ifndef NO_ASSERTIONS
  a_last_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall && in_last_byte) |=> out_valid)
    else $error("final beat did not produce a result");

  a_mask_absent_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_has_mask) |-> (out_subnet_mask == 32'd0))
    else $error("subnet mask nonzero without presence flag");

  a_router_absent_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_has_router) |-> (out_router_addr == 32'd0))
    else $error("router address nonzero without presence flag");

  a_match_uses_cfg: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall && in_last_byte) |=>
      (!out_type_matches || (out_msg_type == exp_type_r)))
    else $error("type match disagrees with expected type");
`endif

endmodule

[tb/testbench.sv]
module testbench
  import dhcpop_pkg::*;
;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT = 200_000;
  localparam int HOLD_CYCLES = 300;
  localparam int PHASE_BYTES = 225;
  localparam int NUM_SETTINGS = 5;
  localparam logic [7:0] NO_OPT = 8'd0;

  typedef struct {
    logic [7:0] data;
    logic       last;
    bit         pinned;
    result_t    want;
  } dir_row_t;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  logic [7:0]  in_opt_byte;
  logic        in_last_byte;
  logic        out_valid;
  logic        out_stall;
  logic [7:0]  out_msg_type;
  logic        out_type_matches;
  logic [31:0] out_subnet_mask;
  logic        out_has_mask;
  logic [31:0] out_router_addr;
  logic        out_has_router;
  logic        out_truncated;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [7:0]  cfg_expected_type;

  // Predictor state, one copy of the block's parse registers.
  phase_t      parse_phase;
  logic [7:0]  cur_option;
  logic [7:0]  value_left;
  logic [2:0]  value_idx;
  logic [7:0]  cap_type;
  logic [31:0] cap_mask;
  logic [31:0] cap_router;
  logic [2:0]  seen;
  logic [7:0]  expected_type_setting = EXPECTED_TYPE_RST;

  result_t     pending_results[$];
  logic [7:0]  packet_bytes[$];
  dir_row_t    dir_rows[$];

  int          cycle_count = 0;
  int          mismatches = 0;
  int          results_seen = 0;
  int          bytes_sent = 0;
  int          packets_sent = 0;
  int          burst_left = 0;
  int          match_count = 0;
  int          mask_count = 0;
  int          router_count = 0;
  int          trunc_count = 0;
  bit          hold_req = 1'b0;

  dhcp_option_parser_core u_top (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_opt_byte       (in_opt_byte),
    .in_last_byte      (in_last_byte),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_msg_type      (out_msg_type),
    .out_type_matches  (out_type_matches),
    .out_subnet_mask   (out_subnet_mask),
    .out_has_mask      (out_has_mask),
    .out_router_addr   (out_router_addr),
    .out_has_router    (out_has_router),
    .out_truncated     (out_truncated),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_expected_type (cfg_expected_type)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles with %0d results outstanding.", cycle_count,
               pending_results.size());
      $display("FAIL dhcp_option_parser_core");
      $finish;
    end
  end

  function automatic void clear_parse();
    parse_phase = PH_TYPE;
    cur_option  = NO_OPT;
    value_left  = '0;
    value_idx   = '0;
    cap_type    = '0;
    cap_mask    = '0;
    cap_router  = '0;
    seen        = '0;
  endfunction

  // Advances the parse by one byte; returns 1 with the packet result on a last byte.
  function automatic bit parse_option_byte(input logic [7:0] b, input logic last,
                                           output result_t res);
    res = '0;
    case (parse_phase)
      PH_TYPE: begin
        if (b == OPT_END) begin
          parse_phase = PH_DONE;
        end else if (b != OPT_PAD) begin
          cur_option = b;
          parse_phase = PH_LEN;
        end
      end
      PH_LEN: begin
        value_left = b;
        value_idx = '0;
        // Address options too short to hold an address are skipped whole.
        if ((cur_option == OPT_MASK || cur_option == OPT_ROUTER) && b < 8'(ADDR_LEN))
          cur_option = NO_OPT;
        if (b == 8'd0)
          parse_phase = PH_TYPE;
        else
          parse_phase = PH_VALUE;
      end
      PH_VALUE: begin
        if (cur_option == OPT_MSGTYPE) begin
          if (value_idx == 3'd0 && !seen[SEEN_TYPE]) begin
            cap_type = b;
            seen[SEEN_TYPE] = 1'b1;
          end
        end else if (cur_option == OPT_MASK && value_idx < ADDR_LEN) begin
          if (value_idx == 3'd0)
            seen[SEEN_MASK] = 1'b0;
          cap_mask = {cap_mask[23:0], b};
          if (value_idx == ADDR_LEN - 3'd1)
            seen[SEEN_MASK] = 1'b1;
        end else if (cur_option == OPT_ROUTER && value_idx < ADDR_LEN) begin
          if (value_idx == 3'd0)
            seen[SEEN_ROUTER] = 1'b0;
          cap_router = {cap_router[23:0], b};
          if (value_idx == ADDR_LEN - 3'd1)
            seen[SEEN_ROUTER] = 1'b1;
        end
        if (value_idx < ADDR_LEN)
          value_idx = value_idx + 3'd1;
        value_left = value_left - 8'd1;
        if (value_left == 8'd0)
          parse_phase = PH_TYPE;
      end
      default: ;
    endcase
    if (!last)
      return 1'b0;
    res.msg_type     = seen[SEEN_TYPE] ? cap_type : 8'd0;
    res.type_matches = seen[SEEN_TYPE] && cap_type == expected_type_setting;
    res.subnet_mask  = seen[SEEN_MASK] ? cap_mask : 32'd0;
    res.has_mask     = seen[SEEN_MASK];
    res.router_addr  = seen[SEEN_ROUTER] ? cap_router : 32'd0;
    res.has_router   = seen[SEEN_ROUTER];
    res.truncated    = parse_phase == PH_LEN || parse_phase == PH_VALUE;
    clear_parse();
    return 1'b1;
  endfunction

  function automatic result_t result_of(input logic [7:0] msg, input logic match,
                                        input logic [31:0] mask, input logic hm,
                                        input logic [31:0] router, input logic hr,
                                        input logic trunc);
    result_t r;
    r.msg_type     = msg;
    r.type_matches = match;
    r.subnet_mask  = mask;
    r.has_mask     = hm;
    r.router_addr  = router;
    r.has_router   = hr;
    r.truncated    = trunc;
    return r;
  endfunction

  function automatic dir_row_t beat(input logic [7:0] data);
    dir_row_t row;
    row = '{data, 1'b0, 1'b0, '0};
    return row;
  endfunction

  function automatic dir_row_t closing_beat(input logic [7:0] data, input result_t want);
    dir_row_t row;
    row = '{data, 1'b1, 1'b1, want};
    return row;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("[%0t] result %0d: %s got 0x%0h, expected 0x%0h", $time, results_seen, what,
             got, want);
    mismatches++;
  endtask

  // Sender: bursts of beats with random gaps; the prediction runs once a beat is taken.
  task automatic send_byte(input logic [7:0] data, input logic last, input bit pinned,
                           input result_t want);
    int gap;
    result_t predicted;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        in_valid <= 1'b0;
        in_opt_byte <= 8'($urandom);
        in_last_byte <= 1'($urandom);
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_valid <= 1'b1;
    in_opt_byte <= data;
    in_last_byte <= last;
    do @(posedge clk); while (in_stall);
    bytes_sent++;
    if (last)
      packets_sent++;
    if (parse_option_byte(data, last, predicted))
      pending_results.push_back(pinned ? want : predicted);
  endtask

  // The register may only change with no packet in flight, so drain first.
  task automatic write_expected_type(input logic [7:0] value);
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_expected_type <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    expected_type_setting = value;
  endtask

  function automatic logic [7:0] pick_msg_type(input logic [7:0] want_type);
    case ($urandom_range(0, 5))
      0: return 8'd0;
      1: return 8'hFF;
      2: return 8'($urandom);
      default: return want_type;
    endcase
  endfunction

  // Mostly well-formed option lists with random content, some cut short, some pure noise.
  function automatic void build_packet(input logic [7:0] want_type);
    int n_opts;
    int len;
    logic [7:0] code;
    bit ended;
    packet_bytes.delete();
    if ($urandom_range(0, 7) == 0) begin
      repeat ($urandom_range(1, 12)) packet_bytes.push_back(8'($urandom));
      return;
    end
    n_opts = $urandom_range(1, 5);
    ended = 1'b0;
    for (int k = 0; k < n_opts && !ended; k++) begin
      len = 0;
      case ($urandom_range(0, 9))
        0: code = OPT_PAD;
        1, 2: begin
          code = OPT_MSGTYPE;
          len = ($urandom_range(0, 6) == 0) ? $urandom_range(0, 3) : 1;
        end
        3, 4: begin
          code = OPT_MASK;
          len = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 8) : 4;
        end
        5, 6: begin
          code = OPT_ROUTER;
          len = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 3) : 4 * $urandom_range(1, 2);
        end
        7, 8: begin
          code = 8'($urandom);
          len = $urandom_range(0, 6);
        end
        default: code = OPT_END;
      endcase
      packet_bytes.push_back(code);
      if (code == OPT_END) begin
        ended = 1'b1;
      end else if (code != OPT_PAD) begin
        packet_bytes.push_back(8'(len));
        for (int i = 0; i < len; i++)
          packet_bytes.push_back((code == OPT_MSGTYPE && i == 0) ?
                                 pick_msg_type(want_type) : 8'($urandom));
      end
    end
    if (!ended && $urandom_range(0, 1) == 0)
      packet_bytes.push_back(OPT_END);
    repeat ($urandom_range(0, 3)) packet_bytes.push_back(8'($urandom));
    if ($urandom_range(0, 6) == 0) begin
      len = $urandom_range(1, packet_bytes.size());
      while (packet_bytes.size() > len) void'(packet_bytes.pop_back());
    end
  endfunction

  // Receiver: stall pattern of its own, plus one long hold-off on request.
  initial begin
    int mode;
    int span;
    int k;
    forever begin
      if (hold_req) begin
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_req = 1'b0;
      end else begin
        mode = $urandom_range(0, 3);
        span = $urandom_range(8, 64);
        for (k = 0; k < span; k++) begin
          case (mode)
            0: out_stall <= 1'b0;
            1: out_stall <= ($urandom_range(0, 3) == 0);
            2: out_stall <= ($urandom_range(0, 3) != 0);
            default: out_stall <= k[2];
          endcase
          @(posedge clk);
        end
      end
    end
  end

  always @(posedge clk) begin : watch_results
    result_t got;
    result_t want;
    if (rst_n === 1'b1 && out_valid && !out_stall) begin
      got.msg_type     = out_msg_type;
      got.type_matches = out_type_matches;
      got.subnet_mask  = out_subnet_mask;
      got.has_mask     = out_has_mask;
      got.router_addr  = out_router_addr;
      got.has_router   = out_has_router;
      got.truncated    = out_truncated;
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected result, msg_type", 32'(got.msg_type), 32'd0);
      end else begin
        want = pending_results.pop_front();
        if (got.msg_type !== want.msg_type)
          report_mismatch("msg_type", 32'(got.msg_type), 32'(want.msg_type));
        if (got.type_matches !== want.type_matches)
          report_mismatch("type_matches", 32'(got.type_matches), 32'(want.type_matches));
        if (got.subnet_mask !== want.subnet_mask)
          report_mismatch("subnet_mask", got.subnet_mask, want.subnet_mask);
        if (got.has_mask !== want.has_mask)
          report_mismatch("has_mask", 32'(got.has_mask), 32'(want.has_mask));
        if (got.router_addr !== want.router_addr)
          report_mismatch("router_addr", got.router_addr, want.router_addr);
        if (got.has_router !== want.has_router)
          report_mismatch("has_router", 32'(got.has_router), 32'(want.has_router));
        if (got.truncated !== want.truncated)
          report_mismatch("truncated", 32'(got.truncated), 32'(want.truncated));
        match_count  += int'(want.type_matches);
        mask_count   += int'(want.has_mask);
        router_count += int'(want.has_router);
        trunc_count  += int'(want.truncated);
      end
      results_seen++;
    end
  end

  initial begin
    logic [7:0] type_settings[NUM_SETTINGS];
    int phase_start;
    in_valid <= 1'b0;
    in_opt_byte <= 8'd0;
    in_last_byte <= 1'b0;
    cfg_valid <= 1'b0;
    cfg_expected_type <= 8'd0;
    rst_n <= 1'b0;
    clear_parse();
    type_settings = '{8'd0, 8'd255, 8'd2, 8'($urandom), EXPECTED_TYPE_RST};

    // Directed packets run with the reset value of the expected type.
    dir_rows = '{
      // A lone pad as the whole area: nothing captured, no type so no match.
      closing_beat(OPT_PAD, result_of(8'd0, 1'b0, 32'd0, 1'b0, 32'd0, 1'b0, 1'b0)),
      // Type and all-ones mask, then the end option with a trailing byte ignored.
      beat(OPT_MSGTYPE), beat(8'd1), beat(8'd5),
      beat(OPT_MASK), beat(8'd4), beat(8'hFF), beat(8'hFF), beat(8'hFF), beat(8'hFF),
      beat(OPT_END),
      closing_beat(8'd7, result_of(8'd5, 1'b1, 32'hFFFF_FFFF, 1'b1, 32'd0, 1'b0, 1'b0)),
      // Short router skipped, zero-length type not seen, mask cut off by the end.
      beat(OPT_ROUTER), beat(8'd2), beat(8'd9), beat(8'd9),
      beat(OPT_MSGTYPE), beat(8'd0),
      beat(OPT_MASK), beat(8'd4), beat(8'd1),
      closing_beat(8'd2, result_of(8'd0, 1'b0, 32'd0, 1'b0, 32'd0, 1'b0, 1'b1)),
      // Area ends on a maximal length byte.
      beat(OPT_MSGTYPE),
      closing_beat(8'hFF, result_of(8'd0, 1'b0, 32'd0, 1'b0, 32'd0, 1'b0, 1'b1))
    };

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (dir_rows[i])
      send_byte(dir_rows[i].data, dir_rows[i].last, dir_rows[i].pinned, dir_rows[i].want);

    for (int p = 0; p < NUM_SETTINGS; p++) begin
      write_expected_type(type_settings[p]);
      if (p == 1)
        hold_req = 1'b1;
      phase_start = bytes_sent;
      while (bytes_sent - phase_start < PHASE_BYTES) begin
        build_packet(expected_type_setting);
        foreach (packet_bytes[i])
          send_byte(packet_bytes[i], i == packet_bytes.size() - 1, 1'b0, '0);
      end
    end

    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);

    $display("Sent %0d option bytes in %0d packets over %0d expected-type settings; %0d results.",
             bytes_sent, packets_sent, NUM_SETTINGS + 1, results_seen);
    $display("Results with a type match %0d, a mask %0d, a router %0d, truncation %0d.",
             match_count, mask_count, router_count, trunc_count);
    if (mismatches == 0)
      $display("PASS dhcp_option_parser_core");
    else
      $display("FAIL dhcp_option_parser_core");
    $finish;
  end

endmodule
